>>> hdl/tsip_frame_field_decoder_top_assert.svh
// Assertion macros for the TSIP frame field decoder.
`ifndef TSIP_FRAME_FIELD_DECODER_TOP_ASSERT_SVH
`define TSIP_FRAME_FIELD_DECODER_TOP_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define TFFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TFFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tffd_pkg.sv
// Package with types, constants and field tables of the TSIP frame field decoder.
`timescale 1ns / 1ps

package tffd_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 64;

  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] ID_TRK   = 8'h5c;
  localparam logic [7:0] ID_SEL   = 8'h6d;
  localparam logic [7:0] ID_TIM   = 8'h8f;
  localparam logic [7:0] SUB_TIM  = 8'hab;

  localparam int unsigned LEN_TRK      = 25;
  localparam int unsigned LEN_TIM      = 18;
  localparam int unsigned LEN_SEL_BASE = 18;

  localparam logic [4:0] LAST_TRK     = 5'd12;
  localparam logic [4:0] LAST_TIM     = 5'd9;
  localparam logic [4:0] LAST_SEL_MIN = 5'd6;

  typedef enum logic [1:0] {
    KIND_TRK = 2'd0,
    KIND_SEL = 2'd1,
    KIND_TIM = 2'd2,
    KIND_UNK = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_LEN   = 2'd1,
    STS_UNHANDLED = 2'd2,
    STS_OVERFLOW  = 2'd3
  } status_e;

  // Post-processing applied to an assembled field.
  typedef enum logic [2:0] {
    OP_RAW  = 3'd0,
    OP_LO3  = 3'd1,
    OP_BIT3 = 3'd2,
    OP_HI4  = 3'd3,
    OP_HI5  = 3'd4
  } fld_op_e;

  typedef struct packed {
    logic [5:0] addr;
    logic [2:0] nbytes;
    fld_op_e    op;
  } fld_desc_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic store;
    logic close;
    logic begin_fld;
    logic rd;
    logic acc;
    logic load;
    logic next;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_dle;
    logic is_etx;
    logic err;
    logic cnt_zero;
    logic last;
  } dp_sts_t;

  // Start byte, byte count and operation of field idx of a packet kind.
  function automatic fld_desc_t field_map(input kind_e kind, input logic [4:0] idx);
    fld_desc_t d;
    d = '{addr: 6'd0, nbytes: 3'd1, op: OP_RAW};
    case (kind)
      KIND_TRK: begin
        case (idx)
          5'd0: d.addr = 6'd1;
          5'd1: begin
            d.addr = 6'd2;
            d.op   = OP_LO3;
          end
          5'd2: begin
            d.addr = 6'd2;
            d.op   = OP_HI5;
          end
          5'd3: d.addr = 6'd3;
          5'd4: d.addr = 6'd4;
          5'd5: begin
            d.addr   = 6'd5;
            d.nbytes = 3'd4;
          end
          5'd6: begin
            d.addr   = 6'd9;
            d.nbytes = 3'd4;
          end
          5'd7: begin
            d.addr   = 6'd13;
            d.nbytes = 3'd4;
          end
          5'd8: begin
            d.addr   = 6'd17;
            d.nbytes = 3'd4;
          end
          5'd9, 5'd10, 5'd11, 5'd12: d.addr = 6'(idx) + 6'd12;
          default: d.addr = 6'd0;
        endcase
      end
      KIND_SEL: begin
        case (idx)
          5'd0: begin
            d.addr = 6'd1;
            d.op   = OP_LO3;
          end
          5'd1: begin
            d.addr = 6'd1;
            d.op   = OP_BIT3;
          end
          5'd2: begin
            d.addr = 6'd1;
            d.op   = OP_HI4;
          end
          5'd3: begin
            d.addr   = 6'd2;
            d.nbytes = 3'd4;
          end
          5'd4: begin
            d.addr   = 6'd6;
            d.nbytes = 3'd4;
          end
          5'd5: begin
            d.addr   = 6'd10;
            d.nbytes = 3'd4;
          end
          5'd6: begin
            d.addr   = 6'd14;
            d.nbytes = 3'd4;
          end
          // satellite numbers follow the fixed part at byte 18
          default: d.addr = 6'(idx) + 6'd11;
        endcase
      end
      KIND_TIM: begin
        case (idx)
          5'd0: begin
            d.addr   = 6'd2;
            d.nbytes = 3'd4;
          end
          5'd1: begin
            d.addr   = 6'd6;
            d.nbytes = 3'd2;
          end
          5'd2: begin
            d.addr   = 6'd8;
            d.nbytes = 3'd2;
          end
          5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8: d.addr = 6'(idx) + 6'd7;
          5'd9: begin
            d.addr   = 6'd16;
            d.nbytes = 3'd2;
          end
          default: d.addr = 6'd0;
        endcase
      end
      default: d.addr = 6'd0;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] apply_op(input fld_op_e op, input logic [31:0] val);
    logic [31:0] r;
    case (op)
      OP_LO3:  r = {29'd0, val[2:0]};
      OP_BIT3: r = {31'd0, val[3]};
      OP_HI4:  r = {28'd0, val[7:4]};
      OP_HI5:  r = {27'd0, val[7:3]};
      default: r = val;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/tffd_ctrl.sv
// Controller: byte unframing and field emission sequencer.
`timescale 1ns / 1ps

module tffd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tffd_pkg::dp_sts_t sts_i,
  output tffd_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_RECV  = 5'b00001,
    S_SETUP = 5'b00010,
    S_READ  = 5'b00100,
    S_ACC   = 5'b01000,
    S_WAIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   in_frame_q, in_frame_d;
  logic   esc_q, esc_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == S_RECV);
  assign out_valid_o = (state_q == S_WAIT);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cmd_o      = '0;
    case (state_q)
      S_RECV: begin
        if (in_fire) begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (sts_i.is_etx) begin
              cmd_o.close = 1'b1;
              in_frame_d  = 1'b0;
              state_d     = S_SETUP;
            end else begin
              cmd_o.store = 1'b1;
            end
          end else if (in_frame_q) begin
            if (sts_i.is_dle) begin
              esc_d = 1'b1;
            end else begin
              cmd_o.store = 1'b1;
            end
          end else if (sts_i.is_dle) begin
            in_frame_d = 1'b1;
          end
        end
      end
      S_SETUP: begin
        if (sts_i.err) begin
          state_d = S_WAIT;
        end else begin
          cmd_o.begin_fld = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.cnt_zero) begin
          cmd_o.load = 1'b1;
          state_d    = S_WAIT;
        end else begin
          state_d = S_READ;
        end
      end
      S_WAIT: begin
        if (out_ready_i) begin
          if (sts_i.last) begin
            state_d = S_RECV;
          end else begin
            cmd_o.next = 1'b1;
            state_d    = S_SETUP;
          end
        end
      end
      default: state_d = S_RECV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RECV;
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
    end
  end

endmodule

>>> hdl/tffd_datapath.sv
// Datapath: frame buffer, packet classification and field assembly.
`timescale 1ns / 1ps

module tffd_datapath #(
  parameter int unsigned FRAME_DEPTH = tffd_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tffd_pkg::ctl_cmd_t cmd_i,
  input  logic [7:0]         rx_byte_i,
  output tffd_pkg::dp_sts_t  sts_o,
  output logic [1:0]         packet_kind_o,
  output logic [1:0]         status_o,
  output logic [4:0]         field_index_o,
  output logic [31:0]        field_value_o,
  output logic               last_field_o
);

  localparam int unsigned ADDR_W = $clog2(FRAME_DEPTH);
  localparam int unsigned LEN_W  = $clog2(FRAME_DEPTH + 1);

  logic [7:0]        mem_q [FRAME_DEPTH];
  logic [7:0]        rdata_q;
  logic [LEN_W-1:0]  len_q;
  logic              ovf_q;
  logic [7:0]        hdr0_q, hdr1_q;
  tffd_pkg::kind_e   kind_q, kind_d;
  tffd_pkg::status_e status_q, status_d;
  logic [4:0]        last_idx_q, last_idx_d;
  logic [4:0]        idx_q;
  logic [ADDR_W-1:0] ptr_q;
  logic [2:0]        cnt_q;
  tffd_pkg::fld_op_e op_q;
  logic [23:0]       acc_q;
  logic [31:0]       value_q;
  logic [31:0]       acc_next;
  logic [3:0]        sats;
  logic              can_store;
  tffd_pkg::fld_desc_t desc;

  assign sats      = hdr1_q[7:4];
  assign can_store = (len_q < LEN_W'(FRAME_DEPTH));
  assign acc_next  = {acc_q, rdata_q};
  assign desc      = tffd_pkg::field_map(kind_q, idx_q);

  // Classification of the closed frame, ordered as overflow, empty, id checks.
  always_comb begin
    kind_d     = tffd_pkg::KIND_UNK;
    status_d   = tffd_pkg::STS_UNHANDLED;
    last_idx_d = 5'd0;
    if (ovf_q) begin
      status_d = tffd_pkg::STS_OVERFLOW;
    end else if (len_q == '0) begin
      status_d = tffd_pkg::STS_UNHANDLED;
    end else if (hdr0_q == tffd_pkg::ID_TRK) begin
      kind_d     = tffd_pkg::KIND_TRK;
      last_idx_d = tffd_pkg::LAST_TRK;
      status_d   = (len_q == LEN_W'(tffd_pkg::LEN_TRK)) ? tffd_pkg::STS_OK
                                                         : tffd_pkg::STS_BAD_LEN;
    end else if (hdr0_q == tffd_pkg::ID_SEL) begin
      kind_d     = tffd_pkg::KIND_SEL;
      last_idx_d = tffd_pkg::LAST_SEL_MIN + {1'b0, sats};
      status_d   = (len_q >= LEN_W'(2) &&
                    len_q == LEN_W'(tffd_pkg::LEN_SEL_BASE) + LEN_W'(sats))
                   ? tffd_pkg::STS_OK : tffd_pkg::STS_BAD_LEN;
    end else if (hdr0_q == tffd_pkg::ID_TIM && len_q >= LEN_W'(2) &&
                 hdr1_q == tffd_pkg::SUB_TIM) begin
      kind_d     = tffd_pkg::KIND_TIM;
      last_idx_d = tffd_pkg::LAST_TIM;
      status_d   = (len_q == LEN_W'(tffd_pkg::LEN_TIM)) ? tffd_pkg::STS_OK
                                                         : tffd_pkg::STS_BAD_LEN;
    end
  end

  // Frame buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && can_store) begin
      mem_q[len_q[ADDR_W-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      idx_q  <= 5'd0;
      cnt_q  <= 3'd0;
      kind_q <= tffd_pkg::KIND_UNK;
      status_q <= tffd_pkg::STS_OK;
    end else begin
      if (cmd_i.store) begin
        if (can_store) begin
          len_q <= len_q + LEN_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.close) begin
        len_q    <= '0;
        ovf_q    <= 1'b0;
        kind_q   <= kind_d;
        status_q <= status_d;
        idx_q    <= 5'd0;
      end
      if (cmd_i.begin_fld) begin
        cnt_q <= desc.nbytes;
      end
      if (cmd_i.rd) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (cmd_i.next) begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && can_store) begin
      if (len_q == LEN_W'(0)) hdr0_q <= rx_byte_i;
      if (len_q == LEN_W'(1)) hdr1_q <= rx_byte_i;
    end
    if (cmd_i.close) begin
      last_idx_q <= last_idx_d;
      value_q    <= 32'd0;
    end
    if (cmd_i.begin_fld) begin
      ptr_q <= ADDR_W'(desc.addr);
      op_q  <= desc.op;
      acc_q <= 24'd0;
    end
    if (cmd_i.rd) begin
      ptr_q <= ptr_q + ADDR_W'(1);
    end
    if (cmd_i.acc) begin
      acc_q <= acc_next[23:0];
    end
    if (cmd_i.load) begin
      value_q <= tffd_pkg::apply_op(op_q, acc_next);
    end
  end

  assign sts_o.is_dle   = (rx_byte_i == tffd_pkg::DLE_BYTE);
  assign sts_o.is_etx   = (rx_byte_i == tffd_pkg::ETX_BYTE);
  assign sts_o.err      = (status_q != tffd_pkg::STS_OK);
  assign sts_o.cnt_zero = (cnt_q == 3'd0);
  assign sts_o.last     = last_field_o;

  assign packet_kind_o = kind_q;
  assign status_o      = status_q;
  assign field_index_o = idx_q;
  assign field_value_o = value_q;
  assign last_field_o  = (status_q != tffd_pkg::STS_OK) || (idx_q == last_idx_q);

endmodule

>>> hdl/tsip_frame_field_decoder_top.sv
// Top level of the TSIP frame field decoder.
`timescale 1ns / 1ps
//
//  chan | handshake               | payload
//  -----+-------------------------+---------------------------------------------------------------
//  in   | in_valid_i/in_ready_o   | rx_byte_i
//  out  | out_valid_o/out_ready_i | packet_kind_o status_o field_index_o field_value_o last_field_o
//
//  Accepted bytes are absorbed in the receive state; the closing ETX is followed by a setup state.
//  An ok field passes through setup, then a read and an accumulate step per buffer read, n = 1, 2 or 4.
//  An error result goes valid through the setup state after the closing ETX is accepted.
//  Input stays not ready while a frame's results go out; output stalls extend that.
//  rst_ni (async, active low) clears framing and control state; the buffer is not
//  cleared, only written entries are ever read.

module tsip_frame_field_decoder_top #(
  parameter int unsigned FRAME_DEPTH = tffd_pkg::FRAME_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  packet_kind_o,
  output logic [1:0]  status_o,
  output logic [4:0]  field_index_o,
  output logic [31:0] field_value_o,
  output logic        last_field_o
);

  tffd_pkg::ctl_cmd_t cmd;
  tffd_pkg::dp_sts_t  sts;
  logic               err_res_ok;
  logic               mid_run_hs;

  // Framing state machine and emission sequencer.
  tffd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Frame buffer, classification and field assembly.
  tffd_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rx_byte_i     (rx_byte_i),
    .sts_o         (sts),
    .packet_kind_o (packet_kind_o),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .field_value_o (field_value_o),
    .last_field_o  (last_field_o)
  );

  // Error results are single, last and carry zero index and value.
  assign err_res_ok = (status_o == tffd_pkg::STS_OK) ||
                      (last_field_o && field_index_o == 5'd0 && field_value_o == 32'd0);
  // Output transaction of a field that is not the final one.
  assign mid_run_hs = out_valid_o && out_ready_i && !last_field_o;

`include "tsip_frame_field_decoder_top_assert.svh"

  // Input is never taken while a result transaction is pending.
  `TFFD_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while result pending")
  `TFFD_ASSERT(a_err_shape, clk_i, rst_ni, !out_valid_o || err_res_ok, "bad error result")
  // After a non-final field the input stays held off.
  `TFFD_ASSERT_NEXT(a_run_holds_input, clk_i, rst_ni, mid_run_hs, !in_ready_o, "input opened mid run")

endmodule

>>> bench/tb_tsip_frame_field_decoder_top.sv
// Self-checking testbench for the TSIP frame field decoder top level.
`timescale 1ns / 1ps

module tb_tsip_frame_field_decoder_top;

  // Run control knobs.
  localparam int unsigned IDLE_PCT    = 6;          // per-cycle idle chance on each side
  localparam int unsigned HOLD_CYCLES = 400;        // long receiver stall in the pressure test
  localparam int unsigned DRAIN_TAIL  = 300;        // quiet cycles after the last result
  localparam int unsigned MAX_REPORTS = 50;         // mismatch lines printed before going quiet
  localparam time         RUN_LIMIT   = 5_000_000;  // ns, hard stop for a hung run

  // One decoded field as seen on the output channel.
  typedef struct packed {
    tffd_pkg::kind_e   kind;
    tffd_pkg::status_e sts;
    logic [4:0]        idx;
    logic [31:0]       val;
    logic              last;
  } field_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  packet_kind_o;
  logic [1:0]  status_o;
  logic [4:0]  field_index_o;
  logic [31:0] field_value_o;
  logic        last_field_o;

  tsip_frame_field_decoder_top #(
    .FRAME_DEPTH(tffd_pkg::FRAME_DEPTH_DEF)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .packet_kind_o(packet_kind_o),
    .status_o     (status_o),
    .field_index_o(field_index_o),
    .field_value_o(field_value_o),
    .last_field_o (last_field_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  field_res_t  field_q[$];    // decoded fields still owed by the DUT, oldest first
  logic [7:0]  pkt_q[$];      // unstuffed packet body about to be framed and sent
  int unsigned err_cnt       = 0;
  int unsigned bytes_sent    = 0;
  int unsigned framed_bytes  = 0;
  int unsigned frames_closed = 0;
  int unsigned fields_seen   = 0;
  int unsigned hold_cycles   = 0;   // receiver stall request, consumed by the receiver
  bit          steady        = 1'b0; // no idling on either side while set

  // Decoder shadow: framing flags plus the unstuffed frame buffer.
  bit          in_frm;
  bit          esc_pend;
  bit          ovf;
  int unsigned flen;
  logic [7:0]  fbuf [tffd_pkg::FRAME_DEPTH_DEF];

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Buffer read; anything at or past the frame length reads as zero.
  function automatic logic [7:0] buf_byte(input int unsigned k);
    return (k < flen && k < tffd_pkg::FRAME_DEPTH_DEF) ? fbuf[k] : 8'h00;
  endfunction

  // Big-endian assembly of n bytes starting at k.
  function automatic logic [31:0] be_field(input int unsigned k, input int unsigned n);
    logic [31:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) acc = {acc[23:0], buf_byte(k + i)};
    return acc;
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    if (flen < tffd_pkg::FRAME_DEPTH_DEF) begin
      fbuf[flen] = b;
      flen++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  // Frame close: classify the buffer and queue every field it decodes to.
  function automatic void close_frame();
    logic [31:0]       v [22];
    int unsigned       nf;
    int unsigned       sats;
    tffd_pkg::kind_e   k;
    tffd_pkg::status_e s;
    logic [7:0]        c;
    nf = 1;
    k  = tffd_pkg::KIND_UNK;
    s  = tffd_pkg::STS_UNHANDLED;
    for (int i = 0; i < 22; i++) v[i] = '0;
    if (ovf) begin
      // overflow wins over every other check
      s = tffd_pkg::STS_OVERFLOW;
    end else if (flen == 0) begin
      s = tffd_pkg::STS_UNHANDLED;
    end else if (fbuf[0] == tffd_pkg::ID_TRK) begin
      k = tffd_pkg::KIND_TRK;
      if (flen != tffd_pkg::LEN_TRK) begin
        s = tffd_pkg::STS_BAD_LEN;
      end else begin
        s     = tffd_pkg::STS_OK;
        nf    = 13;
        c     = buf_byte(2);
        v[0]  = be_field(1, 1);
        v[1]  = {29'd0, c[2:0]};
        v[2]  = {27'd0, c[7:3]};
        v[3]  = be_field(3, 1);
        v[4]  = be_field(4, 1);
        v[5]  = be_field(5, 4);
        v[6]  = be_field(9, 4);
        v[7]  = be_field(13, 4);
        v[8]  = be_field(17, 4);
        for (int i = 0; i < 4; i++) v[9 + i] = be_field(21 + i, 1);
      end
    end else if (fbuf[0] == tffd_pkg::ID_SEL) begin
      k    = tffd_pkg::KIND_SEL;
      c    = buf_byte(1);
      sats = 32'(c[7:4]);
      // a missing flag byte reads as zero and fails the length test anyway
      if (flen < 2 || flen != tffd_pkg::LEN_SEL_BASE + sats) begin
        s = tffd_pkg::STS_BAD_LEN;
      end else begin
        s    = tffd_pkg::STS_OK;
        nf   = 7 + sats;
        v[0] = {29'd0, c[2:0]};
        v[1] = {31'd0, c[3]};
        v[2] = {28'd0, c[7:4]};
        v[3] = be_field(2, 4);
        v[4] = be_field(6, 4);
        v[5] = be_field(10, 4);
        v[6] = be_field(14, 4);
        for (int unsigned i = 0; i < sats; i++) v[7 + i] = be_field(18 + i, 1);
      end
    end else if (fbuf[0] == tffd_pkg::ID_TIM && flen >= 2 && fbuf[1] == tffd_pkg::SUB_TIM) begin
      k = tffd_pkg::KIND_TIM;
      if (flen != tffd_pkg::LEN_TIM) begin
        s = tffd_pkg::STS_BAD_LEN;
      end else begin
        s    = tffd_pkg::STS_OK;
        nf   = 10;
        v[0] = be_field(2, 4);
        v[1] = be_field(6, 2);
        v[2] = be_field(8, 2);
        for (int i = 0; i < 6; i++) v[3 + i] = be_field(10 + i, 1);
        v[9] = be_field(16, 2);
      end
    end
    for (int unsigned i = 0; i < nf; i++)
      field_q.push_back('{k, s, (s == tffd_pkg::STS_OK) ? 5'(i) : 5'd0, v[i], i == nf - 1});
    frames_closed++;
  endfunction

  // Unstuffing state machine, one accepted byte at a time.
  function automatic void absorb_byte(input logic [7:0] b);
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (b == tffd_pkg::ETX_BYTE) begin
        close_frame();
        flen   = 0;
        ovf    = 1'b0;
        in_frm = 1'b0;
      end else begin
        keep_byte(b);
      end
    end else if (in_frm) begin
      if (b == tffd_pkg::DLE_BYTE) esc_pend = 1'b1;
      else keep_byte(b);
    end else if (b == tffd_pkg::DLE_BYTE) begin
      in_frm = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per transaction, driven at the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    // random gaps; valid is only ever dropped in a cycle that then advances
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Frames pkt_q with DLE stuffing. esc_mode 0: only DLE doubled, 1: some other
  // bytes escaped as well, 2: every byte but ETX escaped.
  task automatic send_frame(input int esc_mode);
    logic [7:0] b;
    send_byte(tffd_pkg::DLE_BYTE);
    foreach (pkt_q[i]) begin
      b = pkt_q[i];
      if (b == tffd_pkg::DLE_BYTE) begin
        send_byte(tffd_pkg::DLE_BYTE);
      end else if (b != tffd_pkg::ETX_BYTE &&
                   (esc_mode == 2 || (esc_mode == 1 && $urandom_range(0, 7) == 0))) begin
        send_byte(tffd_pkg::DLE_BYTE);
      end
      send_byte(b);
    end
    send_byte(tffd_pkg::DLE_BYTE);
    send_byte(tffd_pkg::ETX_BYTE);
    framed_bytes += pkt_q.size() + 3;
  endtask

  // Packet body of len bytes led by id; fill < 0 means random payload.
  task automatic build_packet(input logic [7:0] id, input int len, input int fill = -1);
    pkt_q.delete();
    for (int i = 0; i < len; i++) begin
      if (i == 0) pkt_q.push_back(id);
      else if (fill < 0) pkt_q.push_back(8'($urandom));
      else pkt_q.push_back(8'(fill));
    end
  endtask

  // Well-formed packet of a kind, length skewed by delta for error cases.
  task automatic build_kind(input tffd_pkg::kind_e k, input int sats, input int delta,
                            input int fill = -1);
    case (k)
      tffd_pkg::KIND_TRK: build_packet(tffd_pkg::ID_TRK, tffd_pkg::LEN_TRK + delta, fill);
      tffd_pkg::KIND_SEL: begin
        build_packet(tffd_pkg::ID_SEL, tffd_pkg::LEN_SEL_BASE + sats + delta, fill);
        if (pkt_q.size() > 1) pkt_q[1] = {4'(sats), 4'($urandom)};
      end
      default: begin
        build_packet(tffd_pkg::ID_TIM, tffd_pkg::LEN_TIM + delta, fill);
        if (pkt_q.size() > 1) pkt_q[1] = tffd_pkg::SUB_TIM;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready driven at the falling edge, with an optional long hold
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    field_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      fields_seen++;
      if (field_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d sts=%0d idx=%0d val=%08h last=%0b",
                                  packet_kind_o, status_o, field_index_o, field_value_o,
                                  last_field_o));
      end else begin
        want = field_q.pop_front();
        if (packet_kind_o !== want.kind || status_o !== want.sts ||
            field_index_o !== want.idx || field_value_o !== want.val ||
            last_field_o !== want.last) begin
          report_mismatch($sformatf(
            "got kind=%0d sts=%0d idx=%0d val=%08h last=%0b, want %0d %0d %0d %08h %0b",
            packet_kind_o, status_o, field_index_o, field_value_o, last_field_o,
            want.kind, want.sts, want.idx, want.val, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes outside a frame, ETX and extremes among them, must be skipped.
  task automatic test_noise_skip();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(tffd_pkg::ETX_BYTE);
    send_byte(tffd_pkg::ID_TRK);
  endtask

  // Stuffed DLE and a bare ETX inside the payload, some bytes escaped.
  task automatic test_tracking_status();
    build_kind(tffd_pkg::KIND_TRK, 0, 0);
    pkt_q[5] = tffd_pkg::DLE_BYTE;
    pkt_q[6] = tffd_pkg::ETX_BYTE;
    pkt_q[2] = tffd_pkg::DLE_BYTE;
    send_frame(1);
  endtask

  task automatic test_selection_list();
    build_kind(tffd_pkg::KIND_SEL, 1, 0);
    send_frame(1);
  endtask

  task automatic test_primary_timing();
    build_kind(tffd_pkg::KIND_TIM, 0, 0, 8'hff);
    send_frame(0);
  endtask

  // DLE DLE ETX: a frame with nothing in it.
  task automatic test_empty_frame();
    build_packet(8'h00, 0);
    send_frame(0);
  endtask

  task automatic test_unhandled_id();
    build_packet(8'h00, 2);
    send_frame(0);
    build_packet(tffd_pkg::DLE_BYTE, 1);    // stuffed id byte
    send_frame(0);
    build_packet(tffd_pkg::ID_TIM, 1);      // timing id with no sub-id
    send_frame(0);
    build_packet(tffd_pkg::ID_TIM, 3);
    pkt_q[1] = 8'hac;                       // wrong sub-id
    send_frame(0);
  endtask

  task automatic test_bad_length();
    build_kind(tffd_pkg::KIND_TIM, 0, -1);  // one byte short
    send_frame(0);
    build_kind(tffd_pkg::KIND_TRK, 0, -20);
    send_frame(0);
    build_packet(tffd_pkg::ID_SEL, 1);      // selection list without its flag byte
    send_frame(0);
    build_kind(tffd_pkg::KIND_SEL, 3, -14);
    send_frame(0);
  endtask

  // One byte too many, run with no idling on either side.
  task automatic test_frame_overflow();
    steady = 1'b1;
    build_packet(tffd_pkg::ID_TRK, tffd_pkg::FRAME_DEPTH_DEF + 1);
    send_frame(0);
    // flags must be clear again for the next frame
    build_packet(8'h00, 0);
    send_frame(0);
    steady = 1'b0;
  endtask

  // Receiver stalls for a long stretch while frames keep coming, so the
  // decoder backs up and holds its input off; also the longest field run.
  task automatic test_backpressure();
    hold_cycles = HOLD_CYCLES;
    build_kind(tffd_pkg::KIND_SEL, 15, 0);
    send_frame(0);
    build_packet(8'h00, 0);
    send_frame(0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    in_frm     = 1'b0;
    esc_pend   = 1'b0;
    ovf        = 1'b0;
    flen       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_noise_skip();
    test_tracking_status();
    test_selection_list();
    test_primary_timing();
    test_empty_frame();
    test_unhandled_id();
    test_bad_length();
    test_frame_overflow();
    test_backpressure();

    in_valid_i <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (field_q.size() != 0)
      report_mismatch($sformatf("%0d expected fields never arrived", field_q.size()));

    $display("Summary: %0d bytes in, %0d frames closed, %0d field results checked.",
             bytes_sent, frames_closed, fields_seen);
    $display("Covered all packet kinds, stuffing, length/id/overflow errors, output stalls.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop if the DUT hangs.
  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
